[sv/buddy_page_allocator_assert.svh]
// Assertion macros for the buddy page allocator
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
// Check that a condition implies another on the same edge
`define BPA_ASSERT_IMPL(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Check that a condition implies another on the next edge
`define BPA_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

[sv/bpa_pkg.sv]
// Package with sizes and codes of the buddy page allocator
package bpa_pkg;
  localparam int MaxOrder  = 10;
  localparam int PageCount = 1024;
  localparam int PageShift = 12;
  localparam int Orders    = MaxOrder + 1;
  localparam int PgW       = $clog2(PageCount);
  localparam int LnkW      = PgW + 1;
  localparam int OrdW      = 4;
  localparam logic [LnkW-1:0] Nil = {LnkW{1'b1}};
  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNoBlock = 2'd1;
  localparam logic [1:0] StRange = 2'd2;
  localparam logic OpAlloc = 1'b0;
endpackage

[sv/buddy_page_allocator.sv]
// Top level of the buddy page allocator
//
// Use: pulse start with op, request_size and release_address while busy is
// low; the item is taken at that edge and busy rises. One result later shows
// on block_address and status for a single cycle with done high; busy falls
// in that cycle. The receiver cannot stall; results are never held back. The
// user sets base_address via cfg_we/cfg_data while busy is low; not enforced.
// One sequencer walks the linked lists through one read port per table. An
// allocate tries orders upward until one fits and has a free block, then
// splits it level by level down to the order wanted; a free merges with its
// free buddy level by level while it can. The next item waits for the
// previous result (one item at a time).
// Reset: a clearing pass writes null links, zero order and clear free flags to
// every page, then the initial blocks are pushed in order 0 upward as in a
// fresh region; busy stays high all that time. Configuration writes are taken
// meanwhile.
// Page tables live in RAMs; the per-order list heads live in flip-flops.
`include "buddy_page_allocator_assert.svh"
module buddy_page_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [31:0] request_size,
  input  logic [31:0] release_address,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [31:0] block_address,
  output logic [1:0]  status
);
  localparam int PgW  = bpa_pkg::PgW;
  localparam int LnkW = bpa_pkg::LnkW;
  localparam int OrdW = bpa_pkg::OrdW;

  typedef enum logic [4:0] {
    S_CLEAR, S_INIT, S_IDLE, S_AFIND, S_ASEL, S_URD, S_UWAIT, S_UFIX1, S_UFIX2,
    S_SPLIT, S_PUSH1, S_PUSH2, S_FCHK, S_FWAIT, S_FDEC, S_FMERGE, S_DONE
  } state_t;

  typedef struct packed {
    logic           we;
    logic [PgW-1:0] addr;
  } wr_t;

  state_t state;
  logic [31:0] base;
  logic        cur_op;
  logic [31:0] cur_size;
  logic [PgW:0]      cnt;
  logic [OrdW-1:0]   ord;
  logic [OrdW-1:0]   want;
  logic [PgW-1:0]    pg;
  logic [PgW-1:0]    tgt;
  logic [PgW:0]      left;
  logic [LnkW-1:0]   nx;
  logic [LnkW-1:0]   pv;
  logic [OrdW-1:0]   tgt_ord;
  logic [1:0]        ph;
  logic [LnkW-1:0]   head [bpa_pkg::Orders];
  logic [31:0]       res_addr;
  logic [1:0]        res_st;
  logic              ret_free;

  // RAM ports
  logic            n_we, p_we, o_we, f_we;
  logic [PgW-1:0]  n_wa, p_wa, o_wa, f_wa, rd_a;
  logic [LnkW-1:0] n_wd, p_wd, n_rd, p_rd;
  logic [OrdW-1:0] o_wd, o_rd;
  logic            f_wd, f_rd;

  bpa_ram #(.Width(LnkW), .Depth(bpa_pkg::PageCount)) u_next (
    .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(rd_a), .rdata(n_rd));
  bpa_ram #(.Width(LnkW), .Depth(bpa_pkg::PageCount)) u_prev (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(rd_a), .rdata(p_rd));
  bpa_ram #(.Width(OrdW), .Depth(bpa_pkg::PageCount)) u_ord (
    .clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(rd_a), .rdata(o_rd));
  bpa_ram #(.Width(1), .Depth(bpa_pkg::PageCount)) u_free (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(rd_a), .rdata(f_rd));

  // size fit and offset of a free
  logic [31:0]     off;
  logic            off_ok;
  logic [OrdW-1:0] bit_ord;
  logic [PgW-1:0]  bud;
  logic            bud_ok;
  logic [PgW:0]    blk;
  logic [32:0]     lim;
  logic            fits;

  assign off = release_address - base;
  assign off_ok = (off >> bpa_pkg::PageShift) < 32'(bpa_pkg::PageCount);
  assign bit_ord = (ord >= OrdW'(bpa_pkg::MaxOrder)) ? OrdW'(bpa_pkg::MaxOrder) : ord;
  assign bud = pg ^ PgW'((PgW+1)'(1) << ord);
  assign bud_ok = {1'b0, bud} < (PgW+1)'(bpa_pkg::PageCount);
  assign blk = (PgW+1)'(1) << cnt[OrdW-1:0];
  assign lim = 33'(1) << (bpa_pkg::PageShift + 32'(want));
  assign fits = {1'b0, cur_size} <= lim;

  // single shared read address
  always_comb begin
    rd_a = pg;
    if (state == S_FCHK || state == S_FWAIT || state == S_FDEC) begin
      rd_a = (ph == 2'd0) ? pg : bud;
    end else if (state == S_URD || state == S_UWAIT) begin
      rd_a = tgt;
    end
  end

  // write ports, one writer a cycle per table
  always_comb begin
    n_we = 1'b0; n_wa = tgt; n_wd = bpa_pkg::Nil;
    p_we = 1'b0; p_wa = tgt; p_wd = bpa_pkg::Nil;
    o_we = 1'b0; o_wa = tgt; o_wd = tgt_ord;
    f_we = 1'b0; f_wa = tgt; f_wd = 1'b0;
    unique case (state)
      S_CLEAR: begin
        n_we = 1'b1; n_wa = cnt[PgW-1:0];
        p_we = 1'b1; p_wa = cnt[PgW-1:0];
        o_we = 1'b1; o_wa = cnt[PgW-1:0]; o_wd = '0;
        f_we = 1'b1; f_wa = cnt[PgW-1:0];
      end
      S_UFIX1: begin
        if (pv != bpa_pkg::Nil) begin
          n_we = 1'b1; n_wa = pv[PgW-1:0]; n_wd = nx;
        end
        if (nx != bpa_pkg::Nil) begin
          p_we = 1'b1; p_wa = nx[PgW-1:0]; p_wd = pv;
        end
      end
      S_UFIX2: begin
        n_we = 1'b1; p_we = 1'b1; f_we = 1'b1;
        // record the order of the merged block at its lower page
        if (cur_op != bpa_pkg::OpAlloc) begin
          o_we = 1'b1; o_wa = pg & tgt; o_wd = ord + 1'b1;
        end
      end
      S_PUSH1: begin
        o_we = 1'b1; f_we = 1'b1; f_wd = 1'b1;
        p_we = 1'b1;
        n_we = 1'b1; n_wd = head[tgt_ord];
      end
      S_PUSH2: begin
        if (head[tgt_ord] != bpa_pkg::Nil) begin
          p_we = 1'b1; p_wa = head[tgt_ord][PgW-1:0]; p_wd = LnkW'(tgt);
        end
      end
      S_DONE: begin
        if (cur_op == bpa_pkg::OpAlloc && res_st == bpa_pkg::StOk) begin
          o_we = 1'b1; o_wa = pg; o_wd = ord;
          f_we = 1'b1; f_wa = pg;
        end
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  // sequencer with state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      base <= '0;
      done <= 1'b0;
      left <= (PgW+1)'(bpa_pkg::PageCount);
      for (int i = 0; i < bpa_pkg::Orders; i++) head[i] <= bpa_pkg::Nil;
    end else begin
      done <= 1'b0;
      if (cfg_we) base <= cfg_data;
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == (PgW+1)'(bpa_pkg::PageCount - 1)) begin
            state <= S_INIT;
            cnt <= '0;
          end
        end
        S_INIT: begin
          // carve the region into aligned blocks, smallest first
          if ((left & blk) != '0 ||
              (cnt[OrdW-1:0] == OrdW'(bpa_pkg::MaxOrder) && left >= blk &&
               left != '0)) begin
            left <= left - blk;
            tgt <= PgW'(left - blk);
            tgt_ord <= cnt[OrdW-1:0];
            ret_free <= 1'b1;
            state <= S_PUSH1;
          end else if (cnt[OrdW-1:0] == OrdW'(bpa_pkg::MaxOrder)) begin
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            cur_op <= op;
            cur_size <= request_size;
            res_addr <= '0;
            res_st <= bpa_pkg::StOk;
            ret_free <= 1'b0;
            want <= '0;
            ph <= 2'd0;
            if (op == bpa_pkg::OpAlloc) begin
              state <= S_AFIND;
            end else if (!off_ok) begin
              res_st <= bpa_pkg::StRange;
              state <= S_DONE;
            end else begin
              pg <= PgW'(off >> bpa_pkg::PageShift);
              state <= S_FCHK;
            end
          end
        end
        S_AFIND: begin
          // one order tried per cycle
          if (fits) begin
            ord <= want;
            state <= S_ASEL;
          end else if (want == OrdW'(bpa_pkg::MaxOrder)) begin
            res_st <= bpa_pkg::StNoBlock;
            state <= S_DONE;
          end else begin
            want <= want + 1'b1;
          end
        end
        S_ASEL: begin
          if (head[ord] != bpa_pkg::Nil) begin
            pg <= head[ord][PgW-1:0];
            tgt <= head[ord][PgW-1:0];
            tgt_ord <= ord;
            state <= S_URD;
          end else if (ord == OrdW'(bpa_pkg::MaxOrder)) begin
            res_st <= bpa_pkg::StNoBlock;
            state <= S_DONE;
          end else begin
            ord <= ord + 1'b1;
          end
        end
        S_URD: state <= S_UWAIT;
        S_UWAIT: begin
          nx <= n_rd;
          pv <= p_rd;
          tgt_ord <= (o_rd > OrdW'(bpa_pkg::MaxOrder)) ? OrdW'(bpa_pkg::MaxOrder) : o_rd;
          state <= S_UFIX1;
        end
        S_UFIX1: begin
          if (pv == bpa_pkg::Nil) head[tgt_ord] <= nx;
          state <= S_UFIX2;
        end
        S_UFIX2: begin
          if (cur_op == bpa_pkg::OpAlloc) begin
            state <= S_SPLIT;
          end else begin
            pg <= pg & tgt;
            ord <= ord + 1'b1;
            ph <= 2'd0;
            state <= S_FCHK;
          end
        end
        S_SPLIT: begin
          if (ord > want) begin
            tgt <= pg ^ PgW'((PgW+1)'(1) << (ord - 1'b1));
            tgt_ord <= ord - 1'b1;
            ord <= ord - 1'b1;
            state <= S_PUSH1;
          end else begin
            res_addr <= base + (32'(pg) << bpa_pkg::PageShift);
            state <= S_DONE;
          end
        end
        S_PUSH1: state <= S_PUSH2;
        S_PUSH2: begin
          head[tgt_ord] <= LnkW'(tgt);
          if (ret_free) begin
            state <= S_INIT;
          end else if (cur_op == bpa_pkg::OpAlloc) begin
            state <= S_SPLIT;
          end else begin
            state <= S_DONE;
          end
        end
        S_FCHK: state <= S_FWAIT;
        S_FWAIT: begin
          if (ph == 2'd0) begin
            // own page: free flag and stored order
            if (f_rd) begin
              state <= S_DONE;
            end else begin
              ord <= (o_rd > OrdW'(bpa_pkg::MaxOrder)) ? OrdW'(bpa_pkg::MaxOrder) : o_rd;
              ph <= 2'd1;
              state <= S_FDEC;
            end
          end else begin
            state <= S_FMERGE;
          end
        end
        S_FDEC: begin
          // buddy read issued on the shared port
          state <= S_FWAIT;
        end
        S_FMERGE: begin
          if (bit_ord < OrdW'(bpa_pkg::MaxOrder) && bud_ok && f_rd && o_rd == ord) begin
            tgt <= bud;
            state <= S_URD;
          end else begin
            tgt <= pg;
            tgt_ord <= ord;
            state <= S_PUSH1;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          block_address <= res_addr;
          status <= res_st;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BPA_ASSERT_IMPL(a_done_idle, clk, rst, done, state == S_IDLE)
  `BPA_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `BPA_ASSERT_IMPL(a_fail_zero, clk, rst, done && status != bpa_pkg::StOk, block_address == '0)
endmodule

[sv/bpa_ram.sv]
// Generic single-write RAM with registered read
module bpa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write then read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
